// ===== rtl/ssp_pkg.sv =====
// Shared types and constants for the sprite screen projection pipeline.
// No dependencies; used by every module under rtl/.
package ssp_pkg;

    // screen defaults for the top level parameters
    localparam int SCREEN_WIDTH_DEF  = 1024;
    localparam int SCREEN_HEIGHT_DEF = 512;

    // quotient bits produced by each divider before saturation
    localparam int QUOT_W = 32;

    // configuration register indexes
    localparam logic [7:0] REG_VIEWER_X   = 8'd0;
    localparam logic [7:0] REG_VIEWER_Y   = 8'd1;
    localparam logic [7:0] REG_DIR_X      = 8'd2;
    localparam logic [7:0] REG_DIR_Y      = 8'd3;
    localparam logic [7:0] REG_PLANE_X    = 8'd4;
    localparam logic [7:0] REG_PLANE_Y    = 8'd5;
    localparam logic [7:0] REG_VIEW_PITCH = 8'd6;

    // register reset values
    localparam logic [15:0] DIR_X_RST   = 16'd16384;
    localparam logic [15:0] PLANE_Y_RST = 16'd10813;

    // configuration as seen by the pipeline
    typedef struct packed {
        logic signed [31:0] viewer_x;
        logic signed [31:0] viewer_y;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [15:0] plane_x;
        logic signed [15:0] plane_y;
        logic signed [10:0] view_pitch;
    } t_cfg;

    // saturating quotient from a divider
    typedef struct packed {
        logic              ovf;
        logic [QUOT_W-1:0] quot;
    } t_quot;

    // per-item flags carried alongside the divider inputs
    typedef struct packed {
        logic       det_zero;
        logic       depth_neg;
        logic       c_neg;
        logic [7:0] tag;
    } t_side;

endpackage

// ===== rtl/ssp_front.sv =====
// Front stages: viewer offset, camera products, sums, magnitudes and numerators.
// Depends on ssp_pkg (t_cfg, t_side).
module ssp_front #(
    parameter int SCREEN_WIDTH  = ssp_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = ssp_pkg::SCREEN_HEIGHT_DEF,
    parameter int NCW           = 51 + $clog2(SCREEN_WIDTH / 2 + 1),
    parameter int NHW           = 33 + $clog2(4 * SCREEN_HEIGHT + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic signed [31:0]   i_sprite_x,
    input  logic signed [31:0]   i_sprite_y,
    input  logic [7:0]           i_tag,
    input  ssp_pkg::t_cfg        i_cfg,
    output logic                 o_valid,
    output logic [63:0]          o_num_d,
    output logic [32:0]          o_den_d,
    output logic [NCW-1:0]       o_num_c,
    output logic [49:0]          o_den_n,
    output logic [NHW-1:0]       o_num_h,
    output ssp_pkg::t_side       o_side
);

    localparam int HB = NHW - 33;
    localparam logic [HB-1:0] HEIGHT4 = HB'(4 * SCREEN_HEIGHT);
    localparam int WB = NCW - 51;
    localparam logic [WB-1:0] HALF_W  = WB'(SCREEN_WIDTH / 2);

    logic [5:1] r_v;

    // stage 1
    logic signed [32:0] r_dx, r_dy, r_det;
    logic [7:0]         r_tag1;
    logic signed [31:0] w_p1, w_p2;
    // stage 2
    logic signed [48:0] r_m1, r_m2, r_m3, r_m4;
    logic signed [32:0] r_det2;
    logic [7:0]         r_tag2;
    // stage 3
    logic signed [49:0] r_nx, r_ny;
    logic signed [32:0] r_det3;
    logic [7:0]         r_tag3;
    // stage 4
    logic signed [50:0] r_sum;
    logic [49:0]        r_ny_abs;
    logic               r_ny_neg;
    logic [32:0]        r_det_abs;
    logic               r_det_neg, r_det_zero;
    logic [7:0]         r_tag4;
    // stage 5
    logic [50:0]        w_sum_abs;

    assign w_p1 = i_cfg.plane_x * i_cfg.dir_y;
    assign w_p2 = i_cfg.plane_y * i_cfg.dir_x;
    assign w_sum_abs = r_sum[50] ? (51'd0 - r_sum) : r_sum;

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[4:1], i_valid};
        end
    end

    assign o_valid = r_v[5];

    // data stages
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // offset and determinant
            r_dx   <= {i_sprite_x[31], i_sprite_x} - {i_cfg.viewer_x[31], i_cfg.viewer_x};
            r_dy   <= {i_sprite_y[31], i_sprite_y} - {i_cfg.viewer_y[31], i_cfg.viewer_y};
            r_det  <= {w_p1[31], w_p1} - {w_p2[31], w_p2};
            r_tag1 <= i_tag;
            // inverse matrix products
            r_m1   <= i_cfg.dir_y * r_dx;
            r_m2   <= i_cfg.dir_x * r_dy;
            r_m3   <= i_cfg.plane_x * r_dy;
            r_m4   <= i_cfg.plane_y * r_dx;
            r_det2 <= r_det;
            r_tag2 <= r_tag1;
            // lateral and depth terms
            r_nx   <= {r_m1[48], r_m1} - {r_m2[48], r_m2};
            r_ny   <= {r_m3[48], r_m3} - {r_m4[48], r_m4};
            r_det3 <= r_det2;
            r_tag3 <= r_tag2;
            // centre sum and magnitudes
            r_sum      <= {r_ny[49], r_ny} + {r_nx[49], r_nx};
            r_ny_abs   <= r_ny[49] ? (50'd0 - r_ny) : r_ny;
            r_ny_neg   <= r_ny[49];
            r_det_abs  <= r_det3[32] ? (33'd0 - r_det3) : r_det3;
            r_det_neg  <= r_det3[32];
            r_det_zero <= (r_det3 == 33'sd0);
            r_tag4     <= r_tag3;
            // divider operands
            o_num_d          <= {r_ny_abs, 14'd0};
            o_den_d          <= r_det_abs;
            o_num_c          <= NCW'(w_sum_abs) * NCW'(HALF_W);
            o_den_n          <= r_ny_abs;
            o_num_h          <= NHW'(r_det_abs) * NHW'(HEIGHT4);
            o_side.det_zero  <= r_det_zero;
            o_side.depth_neg <= r_ny_neg ^ r_det_neg;
            o_side.c_neg     <= r_sum[50] ^ r_ny_neg;
            o_side.tag       <= r_tag4;
        end
    end

endmodule

// ===== rtl/ssp_div.sv =====
// Pipelined restoring divider on magnitudes, one quotient bit per stage,
// saturating flag when the quotient needs more bits. Depends on ssp_pkg.
module ssp_div #(
    parameter int NW = 64,
    parameter int DW = 33,
    parameter int PW = 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [NW-1:0]         i_num,
    input  logic [DW-1:0]         i_den,
    input  logic [PW-1:0]         i_side,
    output logic                  o_valid,
    output ssp_pkg::t_quot        o_res,
    output logic [PW-1:0]         o_side
);

    localparam int QB = ssp_pkg::QUOT_W;
    localparam int HW = NW - QB;
    localparam int XW = (HW > DW) ? HW : DW;

    logic [XW-1:0] w_hi, w_den_x;

    logic [DW-1:0] r_rem  [0:QB-1];
    logic [QB-1:0] r_low  [0:QB-1];
    logic [DW-1:0] r_den  [0:QB-1];
    logic [QB-1:0] r_q    [0:QB];
    logic          r_ovf  [0:QB];
    logic [PW-1:0] r_side [0:QB];
    logic [QB:0]   r_valid;

    assign w_hi    = XW'(i_num[NW-1:QB]);
    assign w_den_x = XW'(i_den);

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[QB-1:0], i_valid};
        end
    end

    // entry stage: overflow test and initial remainder
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= w_hi[DW-1:0];
            r_low[0]  <= i_num[QB-1:0];
            r_den[0]  <= i_den;
            r_q[0]    <= '0;
            r_ovf[0]  <= (w_hi >= w_den_x);
            r_side[0] <= i_side;
        end
    end

    // one compare and subtract per stage
    for (genvar k = 1; k <= QB; k++) begin : g_step
        logic [DW:0] w_t, w_diff;
        logic        w_ge;

        assign w_t    = {r_rem[k-1], r_low[k-1][QB-1]};
        assign w_ge   = (w_t >= {1'b0, r_den[k-1]});
        assign w_diff = w_t - {1'b0, r_den[k-1]};

        if (k < QB) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= w_ge ? w_diff[DW-1:0] : w_t[DW-1:0];
                    r_low[k] <= {r_low[k-1][QB-2:0], 1'b0};
                    r_den[k] <= r_den[k-1];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[k]    <= {r_q[k-1][QB-2:0], w_ge};
                r_ovf[k]  <= r_ovf[k-1];
                r_side[k] <= r_side[k-1];
            end
        end
    end

    assign o_valid    = r_valid[QB];
    assign o_res.quot = r_q[QB];
    assign o_res.ovf  = r_ovf[QB];
    assign o_side     = r_side[QB];

endmodule

// ===== rtl/ssp_back.sv =====
// Back stages: sign and saturation of quotients, then span clipping into the
// output register. Depends on ssp_pkg (t_quot).
module ssp_back #(
    parameter int SCREEN_WIDTH  = ssp_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = ssp_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  ssp_pkg::t_quot       i_qd,
    input  ssp_pkg::t_quot       i_qc,
    input  ssp_pkg::t_quot       i_qh,
    input  logic [1:0]           i_dside,
    input  logic                 i_c_neg,
    input  logic [7:0]           i_tag,
    input  logic signed [10:0]   i_pitch,
    output logic                 o_valid,
    output logic                 o_visible,
    output logic [31:0]          o_depth,
    output logic [15:0]          o_centre_column,
    output logic [14:0]          o_size_pixels,
    output logic [10:0]          o_column_start,
    output logic [10:0]          o_column_end,
    output logic [9:0]           o_row_start,
    output logic [9:0]           o_row_end,
    output logic [7:0]           o_result_tag
);

    localparam logic signed [35:0] HALF_H = 36'(SCREEN_HEIGHT / 2);
    localparam logic signed [35:0] MAX_H  = 36'(SCREEN_HEIGHT);
    localparam logic signed [35:0] MAX_W  = 36'(SCREEN_WIDTH);

    function automatic logic signed [35:0] f_clamp(input logic signed [35:0] v,
                                                   input logic signed [35:0] lo,
                                                   input logic signed [35:0] hi);
        logic signed [35:0] r;
        r = (v < lo) ? lo : ((v > hi) ? hi : v);
        return r;
    endfunction

    // stage 1 signals
    logic               w_det_zero, w_neg, w_sat_d, w_vis;
    logic [31:0]        w_depth;
    logic [32:0]        w_cmag, w_hmag;
    logic signed [33:0] w_c;
    logic               r_v1, r_vis1;
    logic [31:0]        r_depth1, r_half1;
    logic signed [33:0] r_c1;
    logic [14:0]        r_size1;
    logic [7:0]         r_tag1;
    // stage 2 signals
    logic signed [35:0] w_c36, w_half36, w_pitch36;
    logic signed [35:0] w_cs, w_ce, w_rs, w_re, w_cen;

    // sign and saturation
    assign w_det_zero = i_dside[1];
    assign w_neg      = i_dside[0];
    assign w_sat_d    = i_qd.ovf | i_qd.quot[31];
    assign w_vis      = !w_det_zero && !w_neg && (i_qd.ovf || (i_qd.quot != '0));
    assign w_cmag     = i_qc.ovf ? 33'h1_0000_0000 : {1'b0, i_qc.quot};
    assign w_hmag     = i_qh.ovf ? 33'h1_0000_0000 : {1'b0, i_qh.quot};
    assign w_c        = i_c_neg ? (34'sd0 - $signed({1'b0, w_cmag})) : $signed({1'b0, w_cmag});

    always_comb begin
        if (w_det_zero) begin
            w_depth = 32'd0;
        end else if (w_neg) begin
            w_depth = w_sat_d ? 32'h8000_0000 : (32'd0 - i_qd.quot);
        end else begin
            w_depth = w_sat_d ? 32'h7FFF_FFFF : i_qd.quot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            o_valid <= 1'b0;
        end else if (i_en) begin
            r_v1    <= i_valid;
            o_valid <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_vis1   <= w_vis;
            r_depth1 <= w_depth;
            r_c1     <= w_c;
            r_size1  <= (w_hmag > 33'd32767) ? 15'd32767 : w_hmag[14:0];
            r_half1  <= w_hmag[32:1];
            r_tag1   <= i_tag;
        end
    end

    // span clipping
    assign w_c36     = 36'(r_c1);
    assign w_half36  = $signed({4'd0, r_half1});
    assign w_pitch36 = 36'(i_pitch);
    assign w_cs  = f_clamp(w_c36 - w_half36, 36'sd1, MAX_W);
    assign w_ce  = f_clamp(w_c36 + w_half36, 36'sd0, MAX_W);
    assign w_rs  = f_clamp(HALF_H - w_half36 + w_pitch36, 36'sd0, MAX_H);
    assign w_re  = f_clamp(HALF_H + w_half36 + w_pitch36, 36'sd0, MAX_H);
    assign w_cen = f_clamp(w_c36, -36'sd32768, 36'sd32767);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_visible    <= r_vis1;
            o_depth      <= r_depth1;
            o_result_tag <= r_tag1;
            if (r_vis1) begin
                o_centre_column <= w_cen[15:0];
                o_size_pixels   <= r_size1;
                o_column_start  <= w_cs[10:0];
                o_column_end    <= w_ce[10:0];
                o_row_start     <= w_rs[9:0];
                o_row_end       <= w_re[9:0];
            end else begin
                o_centre_column <= '0;
                o_size_pixels   <= '0;
                o_column_start  <= '0;
                o_column_end    <= '0;
                o_row_start     <= '0;
                o_row_end       <= '0;
            end
        end
    end

endmodule

// ===== rtl/sprite_screen_projection.sv =====
// Top level of the sprite screen projection: configuration registers, stream
// ports and pipeline. Depends on ssp_pkg, ssp_front, ssp_div and ssp_back.
//
//  channel   direction  signals                          payload
//  s_axis    in         i_s_axis_tvalid/o_s_axis_tready  sprite position and tag
//  m_axis    out        o_m_axis_tvalid/i_m_axis_tready  projection result
//  cfg       in         i_cfg_valid/o_cfg_ready          register index and data
//
// One sprite enters per cycle while no result is held at the output. The pipeline
// has five front stages, 33 divider stages (one quotient bit per stage for 32 bits
// plus the overflow test) and two back stages. A transfer stalled at the output freezes every
// stage at once, so nothing is lost or repeated. Reset clears the valid bits
// and loads the register defaults; no clearing pass is needed.
module sprite_screen_projection #(
    parameter int SCREEN_WIDTH  = ssp_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = ssp_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // sprite_x[31:0], sprite_y[63:32], sprite_tag[71:64]
    input  logic [71:0]  i_s_axis_tdata,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // depth[31:0], centre_column[47:32], size_pixels[62:48], column_start[73:63],
    // column_end[84:74], row_start[94:85], row_end[104:95], result_tag[112:105]
    output logic [119:0] o_m_axis_tdata,
    // visible[0]
    output logic         o_m_axis_tuser,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [7:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data
);

    localparam int NHW = 33 + $clog2(4 * SCREEN_HEIGHT + 1);
    localparam int NCW = 51 + $clog2(SCREEN_WIDTH / 2 + 1);

    ssp_pkg::t_cfg  r_cfg;
    logic           w_en;

    logic           w_fv;
    logic [63:0]    w_num_d;
    logic [32:0]    w_den_d;
    logic [NCW-1:0] w_num_c;
    logic [49:0]    w_den_n;
    logic [NHW-1:0] w_num_h;
    ssp_pkg::t_side w_side;

    logic           w_vd, w_vc, w_vh;
    ssp_pkg::t_quot w_qd, w_qc, w_qh;
    logic [1:0]     w_dside;
    logic           w_c_neg;
    logic [7:0]     w_tag;

    logic           w_visible;
    logic [31:0]    w_depth;
    logic [15:0]    w_centre;
    logic [14:0]    w_size;
    logic [10:0]    w_cs, w_ce;
    logic [9:0]     w_rs, w_re;
    logic [7:0]     w_rtag;

    // whole pipeline advances unless a finished result is held
    assign w_en            = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = w_en;
    assign o_cfg_ready     = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.viewer_x   <= '0;
            r_cfg.viewer_y   <= '0;
            r_cfg.dir_x      <= ssp_pkg::DIR_X_RST;
            r_cfg.dir_y      <= '0;
            r_cfg.plane_x    <= '0;
            r_cfg.plane_y    <= ssp_pkg::PLANE_Y_RST;
            r_cfg.view_pitch <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                ssp_pkg::REG_VIEWER_X:   r_cfg.viewer_x   <= i_cfg_data;
                ssp_pkg::REG_VIEWER_Y:   r_cfg.viewer_y   <= i_cfg_data;
                ssp_pkg::REG_DIR_X:      r_cfg.dir_x      <= i_cfg_data[15:0];
                ssp_pkg::REG_DIR_Y:      r_cfg.dir_y      <= i_cfg_data[15:0];
                ssp_pkg::REG_PLANE_X:    r_cfg.plane_x    <= i_cfg_data[15:0];
                ssp_pkg::REG_PLANE_Y:    r_cfg.plane_y    <= i_cfg_data[15:0];
                ssp_pkg::REG_VIEW_PITCH: r_cfg.view_pitch <= i_cfg_data[10:0];
                default: ;
            endcase
        end
    end

    ssp_front #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .NCW           (NCW),
        .NHW           (NHW)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (i_s_axis_tvalid),
        .i_sprite_x (i_s_axis_tdata[31:0]),
        .i_sprite_y (i_s_axis_tdata[63:32]),
        .i_tag      (i_s_axis_tdata[71:64]),
        .i_cfg      (r_cfg),
        .o_valid    (w_fv),
        .o_num_d    (w_num_d),
        .o_den_d    (w_den_d),
        .o_num_c    (w_num_c),
        .o_den_n    (w_den_n),
        .o_num_h    (w_num_h),
        .o_side     (w_side)
    );

    // depth divider
    ssp_div #(.NW(64), .DW(33), .PW(2)) u_div_d (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_fv),
        .i_num   (w_num_d),
        .i_den   (w_den_d),
        .i_side  ({w_side.det_zero, w_side.depth_neg}),
        .o_valid (w_vd),
        .o_res   (w_qd),
        .o_side  (w_dside)
    );

    // centre column divider
    ssp_div #(.NW(NCW), .DW(50), .PW(1)) u_div_c (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_fv),
        .i_num   (w_num_c),
        .i_den   (w_den_n),
        .i_side  (w_side.c_neg),
        .o_valid (w_vc),
        .o_res   (w_qc),
        .o_side  (w_c_neg)
    );

    // size divider
    ssp_div #(.NW(NHW), .DW(50), .PW(8)) u_div_h (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_fv),
        .i_num   (w_num_h),
        .i_den   (w_den_n),
        .i_side  (w_side.tag),
        .o_valid (w_vh),
        .o_res   (w_qh),
        .o_side  (w_tag)
    );

    ssp_back #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (w_en),
        .i_valid         (w_vd),
        .i_qd            (w_qd),
        .i_qc            (w_qc),
        .i_qh            (w_qh),
        .i_dside         (w_dside),
        .i_c_neg         (w_c_neg),
        .i_tag           (w_tag),
        .i_pitch         (r_cfg.view_pitch),
        .o_valid         (o_m_axis_tvalid),
        .o_visible       (w_visible),
        .o_depth         (w_depth),
        .o_centre_column (w_centre),
        .o_size_pixels   (w_size),
        .o_column_start  (w_cs),
        .o_column_end    (w_ce),
        .o_row_start     (w_rs),
        .o_row_end       (w_re),
        .o_result_tag    (w_rtag)
    );

    // result packing
    assign o_m_axis_tdata = {7'd0, w_rtag, w_re, w_rs, w_ce, w_cs, w_size, w_centre, w_depth};
    assign o_m_axis_tuser = w_visible;

    // the three dividers stay in lock step
    a_div_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_vd == w_vc) && (w_vd == w_vh))
        else $error("divider valid bits out of step");

    // a hidden sprite carries no size and no spans
    a_hidden_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser) |->
        ((w_size == '0) && (w_cs == '0) && (w_ce == '0) && (w_rs == '0) && (w_re == '0)))
        else $error("hidden sprite with non-empty result");

    // a visible sprite always has positive depth
    a_visible_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> ($signed(w_depth) > 32'sd0))
        else $error("visible sprite with non-positive depth");

    // a held result does not change until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> (o_m_axis_tvalid && $stable(o_m_axis_tdata)))
        else $error("held result changed");

endmodule

// ===== tb/sv/tb_sprite_screen_projection.sv =====
// Self-checking testbench for sprite_screen_projection: directed and random sprites
// under several register settings and handshake idling patterns.
// Depends on ssp_pkg and the sprite_screen_projection RTL.
module tb_sprite_screen_projection;

    localparam int W = 1024;
    localparam int H = 512;
    localparam int LATENCY = 40;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic        visible;
        logic [31:0] depth;
        logic [15:0] centre_column;
        logic [14:0] size_pixels;
        logic [10:0] column_start;
        logic [10:0] column_end;
        logic [9:0]  row_start;
        logic [9:0]  row_end;
        logic [7:0]  result_tag;
    } t_proj;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [71:0]  s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [119:0] m_tdata;
    logic         m_tuser;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [7:0]   cfg_index = '0;
    logic [31:0]  cfg_data = '0;

    // scoreboard and shared control
    t_proj          proj_queue[$];
    ssp_pkg::t_cfg  cfg_shadow;
    int             err_count = 0;
    int             send_idle_pct = 0;
    int             recv_stall_pct = 0;
    int             hold_off = 0;
    longint         cycles = 0;

    sprite_screen_projection dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    always #1 clk = ~clk;

    // timeout watchdog
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic longint quot_tz(longint a, longint b);
        longint ua, ub, q;
        ua = (a < 0) ? -a : a;
        ub = (b < 0) ? -b : b;
        q  = ua / ub;
        return ((a < 0) != (b < 0)) ? -q : q;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // expected projection of one sprite under the current registers
    function automatic t_proj project_sprite(logic [31:0] sx, logic [31:0] sy, logic [7:0] tag);
        t_proj  r;
        longint dx, dy, dxx, dyy, px, py, pitch, det, nx, ny, ty, c, h, half;
        r = '0;
        dx = longint'($signed(sx)) - longint'(cfg_shadow.viewer_x);
        dy = longint'($signed(sy)) - longint'(cfg_shadow.viewer_y);
        dxx = cfg_shadow.dir_x;
        dyy = cfg_shadow.dir_y;
        px = cfg_shadow.plane_x;
        py = cfg_shadow.plane_y;
        pitch = cfg_shadow.view_pitch;
        det = px * dyy - py * dxx;
        if (det != 0) begin
            nx = dyy * dx - dxx * dy;
            ny = px * dy - py * dx;
            ty = quot_tz(ny * 16384, det);
            r.depth = 32'(clip(ty, -64'sd2147483648, 64'sd2147483647));
            if (ty > 0) begin
                c = quot_tz((W / 2) * (ny + nx), ny);
                h = quot_tz(4 * H * det, ny);
                if (h < 0) h = -h;
                half = h / 2;
                r.visible = 1'b1;
                r.centre_column = 16'(clip(c, -32768, 32767));
                r.size_pixels = 15'(clip(h, 0, 32767));
                r.row_start = 10'(clip(H / 2 - half + pitch, 0, H));
                r.row_end = 10'(clip(H / 2 + half + pitch, 0, H));
                r.column_start = 11'(clip(c - half, 1, W));
                r.column_end = 11'(clip(c + half, 0, W));
            end
        end
        r.result_tag = tag;
        return r;
    endfunction

    task automatic write_reg(logic [7:0] idx, logic [31:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            ssp_pkg::REG_VIEWER_X:   cfg_shadow.viewer_x = val;
            ssp_pkg::REG_VIEWER_Y:   cfg_shadow.viewer_y = val;
            ssp_pkg::REG_DIR_X:      cfg_shadow.dir_x = val[15:0];
            ssp_pkg::REG_DIR_Y:      cfg_shadow.dir_y = val[15:0];
            ssp_pkg::REG_PLANE_X:    cfg_shadow.plane_x = val[15:0];
            ssp_pkg::REG_PLANE_Y:    cfg_shadow.plane_y = val[15:0];
            ssp_pkg::REG_VIEW_PITCH: cfg_shadow.view_pitch = val[10:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_view(logic [31:0] vx, logic [31:0] vy, logic [15:0] dxv,
                            logic [15:0] dyv, logic [15:0] pxv, logic [15:0] pyv,
                            logic [10:0] pitch);
        write_reg(ssp_pkg::REG_VIEWER_X, vx);
        write_reg(ssp_pkg::REG_VIEWER_Y, vy);
        write_reg(ssp_pkg::REG_DIR_X, {{16{dxv[15]}}, dxv});
        write_reg(ssp_pkg::REG_DIR_Y, {{16{dyv[15]}}, dyv});
        write_reg(ssp_pkg::REG_PLANE_X, {{16{pxv[15]}}, pxv});
        write_reg(ssp_pkg::REG_PLANE_Y, {{16{pyv[15]}}, pyv});
        write_reg(ssp_pkg::REG_VIEW_PITCH, {{21{pitch[10]}}, pitch});
    endtask

    // offer one sprite, expectation recorded at the accepting edge
    task automatic send_sprite(logic [31:0] sx, logic [31:0] sy, logic [7:0] tag);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {tag, sy, sx};
        do @(posedge clk); while (!s_tready);
        proj_queue.push_back(project_sprite(sx, sy, tag));
        @(negedge clk);
    endtask

    task automatic finish_sending();
        s_tvalid <= 1'b0;
    endtask

    task automatic drain();
        finish_sending();
        while (proj_queue.size() != 0) @(negedge clk);
        repeat (LATENCY + 5) @(negedge clk);
    endtask

    // receiver back-pressure, with an optional long hold-off
    always @(negedge clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // result checker
    always @(posedge clk) begin
        t_proj got, exp_r;
        if (rst_n && m_tvalid && m_tready) begin
            got.visible       = m_tuser;
            got.depth         = m_tdata[31:0];
            got.centre_column = m_tdata[47:32];
            got.size_pixels   = m_tdata[62:48];
            got.column_start  = m_tdata[73:63];
            got.column_end    = m_tdata[84:74];
            got.row_start     = m_tdata[94:85];
            got.row_end       = m_tdata[104:95];
            got.result_tag    = m_tdata[112:105];
            if (proj_queue.size() == 0) begin
                $error("result with nothing expected: tag %0d", got.result_tag);
                err_count++;
            end else begin
                exp_r = proj_queue.pop_front();
                if (got.visible !== exp_r.visible) begin
                    $error("visible exp %0d got %0d", exp_r.visible, got.visible); err_count++;
                end
                if (got.depth !== exp_r.depth) begin
                    $error("depth exp %0h got %0h", exp_r.depth, got.depth); err_count++;
                end
                if (got.centre_column !== exp_r.centre_column) begin
                    $error("centre_column exp %0h got %0h", exp_r.centre_column,
                           got.centre_column); err_count++;
                end
                if (got.size_pixels !== exp_r.size_pixels) begin
                    $error("size_pixels exp %0d got %0d", exp_r.size_pixels,
                           got.size_pixels); err_count++;
                end
                if (got.column_start !== exp_r.column_start) begin
                    $error("column_start exp %0d got %0d", exp_r.column_start,
                           got.column_start); err_count++;
                end
                if (got.column_end !== exp_r.column_end) begin
                    $error("column_end exp %0d got %0d", exp_r.column_end,
                           got.column_end); err_count++;
                end
                if (got.row_start !== exp_r.row_start) begin
                    $error("row_start exp %0d got %0d", exp_r.row_start, got.row_start);
                    err_count++;
                end
                if (got.row_end !== exp_r.row_end) begin
                    $error("row_end exp %0d got %0d", exp_r.row_end, got.row_end);
                    err_count++;
                end
                if (got.result_tag !== exp_r.result_tag) begin
                    $error("result_tag exp %0d got %0d", exp_r.result_tag,
                           got.result_tag); err_count++;
                end
            end
        end
    end

    // random sprite, mostly near the viewer so that many are visible
    task automatic send_random_sprite();
        logic [31:0] sx, sy;
        int sel;
        sel = $urandom_range(9);
        if (sel < 7) begin
            sx = cfg_shadow.viewer_x + 32'($signed($urandom_range(0, 32'h0010_0000)) -
                                           32'sh0008_0000);
            sy = cfg_shadow.viewer_y + 32'($signed($urandom_range(0, 32'h0010_0000)) -
                                           32'sh0008_0000);
        end else if (sel < 9) begin
            sx = cfg_shadow.viewer_x + ($urandom() >>> $urandom_range(31));
            sy = cfg_shadow.viewer_y + ($urandom() >>> $urandom_range(31));
            if ($urandom_range(1)) sx = ~sx;
        end else begin
            sx = $urandom();
            sy = $urandom();
        end
        send_sprite(sx, sy, 8'($urandom()));
    endtask

    task automatic test_directed();
        logic [31:0] ext[6];
        int t;
        ext = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0001_0000,
                32'h0000_0001};
        t = 0;
        // extremes of the position fields at reset view
        for (int i = 0; i < 6; i++) begin
            send_sprite(ext[i], ext[(i + 2) % 6], 8'(t)); t++;
        end
        // sprite ahead, behind, on the viewer, far and very near
        send_sprite(32'h0002_0000, 32'h0, 8'hFF);
        send_sprite(32'hFFFE_0000, 32'h0, 8'h00);
        send_sprite(32'h0, 32'h0, 8'hAA);
        send_sprite(32'h0000_0010, 32'h0000_0001, 8'h55);
        send_sprite(32'h0001_0000, 32'h0003_0000, 8'h01);
        send_sprite(32'h0001_0000, 32'hFFFD_0000, 8'h80);
        drain();
        // zero determinant: direction parallel to the plane
        set_view(32'h0, 32'h0, 16'h4000, 16'h0, 16'h4000, 16'h0, 11'h0);
        send_sprite(32'h0002_0000, 32'h0001_0000, 8'h11);
        send_sprite(32'h7FFF_FFFF, 32'h8000_0000, 8'h12);
        drain();
        // extreme registers and pitch outside the nominal range
        set_view(32'h8000_0000, 32'h7FFF_FFFF, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000,
                 11'h3FF);
        send_sprite(32'h7FFF_FFFF, 32'h8000_0000, 8'h21);
        send_sprite(32'h8000_0010, 32'h7FFF_0000, 8'h22);
        send_sprite(32'h0, 32'h0, 8'h23);
        drain();
        set_view(32'h0, 32'h0, 16'h4000, 16'h0, 16'h0, 16'h2A3D, 11'h400);
        send_sprite(32'h0000_8000, 32'h0, 8'h31);
        send_sprite(32'h0000_0800, 32'h0, 8'h32);
        drain();
        // register index past the last register is ignored
        write_reg(8'd7, 32'hFFFF_FFFF);
        write_reg(8'hFF, 32'h1234_5678);
    endtask

    task automatic test_random_phase(int n, int idle, int stall);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        repeat (n) send_random_sprite();
        drain();
    endtask

    task automatic test_random_view();
        set_view($urandom(), $urandom(), 16'($urandom()), 16'($urandom()),
                 16'($urandom()), 16'($urandom()), 11'($urandom_range(0, 1024) - 512));
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        @(negedge clk);
        hold_off = 300;
        repeat (120) send_random_sprite();
        drain();
    endtask

    initial begin
        cfg_shadow = '{viewer_x: 0, viewer_y: 0, dir_x: ssp_pkg::DIR_X_RST, dir_y: 0,
                       plane_x: 0, plane_y: ssp_pkg::PLANE_Y_RST, view_pitch: 0};
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        // reset-like view with pitch extremes
        set_view(32'h0, 32'h0, 16'h4000, 16'h0, 16'h0, 16'h2A3D, 11'h200);
        test_random_phase(150, 0, 0);
        set_view(32'h0005_0000, 32'hFFFD_0000, 16'h0, 16'h4000, 16'hD5C3, 16'h0,
                 11'h600);
        test_random_phase(150, 74, 0);
        test_random_view();
        test_random_phase(150, 0, 74);
        test_random_view();
        test_random_phase(150, 33, 33);
        test_random_view();
        test_random_phase(150, 0, 0);
        set_view(32'h0, 32'h0, 16'hC000, 16'h0, 16'h0, 16'hD5C3, 11'h0);
        test_random_phase(150, 33, 33);
        test_backpressure();
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
